@@ rtl/cloud_pixel_first_pass_classifier_assert.svh @@
// Assertion macros used by the checker file of the cloud classifier.
`ifndef CLOUD_PIXEL_FIRST_PASS_CLASSIFIER_ASSERT_SVH
`define CLOUD_PIXEL_FIRST_PASS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CPFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define CPFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cpfp_pkg.sv @@
// Types, constants and register codes of the cloud pixel classifier.
package cpfp_pkg;

  // Default parameter values
  localparam int COUNT_BITS_DEF = 24;
  localparam int TEMP_BITS_DEF  = 13;

  // Fixed field widths
  localparam int REFL_W     = 16;
  localparam int TIN_W      = 13;
  localparam int THR_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed thresholds, pre-scaled for integer compares
  localparam logic [16:0] ONE_Q14     = 17'd16384;
  localparam logic [22:0] DARK7_LIM   = 23'd114688;   // 0.07 * 16384 * 100
  localparam logic [22:0] DARK8_LIM   = 23'd131072;   // 0.08 * 16384 * 100
  localparam logic [22:0] PCT_SCALE   = 23'd100;
  localparam logic [31:0] SHADOW_COMP = 32'd62914560; // 240 K * 16 * 16384

  // Register reset values
  localparam logic              RST_SHADOW_EN  = 1'b0;
  localparam logic [REFL_W-1:0] RST_BRIGHT_THR = 16'd1311;
  localparam logic [THR_W-1:0]  RST_TEMP_THR   = 13'd4800;
  localparam logic [THR_W-1:0]  RST_COMP_THR   = 13'd3600;
  localparam logic [THR_W-1:0]  RST_COLD_THR   = 13'd3360;
  localparam logic [REFL_W-1:0] RST_GROW_RATIO = 16'd9626;
  localparam logic [REFL_W-1:0] RST_SEN_RATIO  = 16'd8857;
  localparam logic [REFL_W-1:0] RST_SOIL_RATIO = 16'd4096;

  typedef enum logic [2:0] {
    CL_NONE   = 3'd0,
    CL_AMBIG  = 3'd1,
    CL_WARM   = 3'd2,
    CL_COLD   = 3'd3,
    CL_SHADOW = 3'd4
  } cls_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHADOW_EN  = 3'd0,
    REG_BRIGHT_THR = 3'd1,
    REG_TEMP_THR   = 3'd2,
    REG_COMP_THR   = 3'd3,
    REG_COLD_THR   = 3'd4,
    REG_GROW_RATIO = 3'd5,
    REG_SEN_RATIO  = 3'd6,
    REG_SOIL_RATIO = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic              shadow_en;
    logic [REFL_W-1:0] bright_thr;
    logic [THR_W-1:0]  temp_thr;
    logic [THR_W-1:0]  comp_thr;
    logic [THR_W-1:0]  cold_thr;
    logic [REFL_W-1:0] grow_ratio;
    logic [REFL_W-1:0] sen_ratio;
    logic [REFL_W-1:0] soil_ratio;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              null_px;
    logic [REFL_W-1:0] green;
    logic [REFL_W-1:0] red;
    logic [REFL_W-1:0] nir;
    logic [REFL_W-1:0] swir;
    logic [TIN_W-1:0]  thermal;
  } pix_t;

  // Class and accumulator update requests for one pixel
  typedef struct packed {
    cls_e cls;
    logic total;
    logic warm;
    logic cold;
    logic snow;
    logic soil;
    logic cloud;
  } upd_t;

endpackage

@@ rtl/cpfp_classify.sv @@
// Threshold tree and shadow test: turns one pixel into a class and update flags.
module cpfp_classify #(
  parameter int TEMP_BITS = cpfp_pkg::TEMP_BITS_DEF
) (
  input  cpfp_pkg::pix_t       pix_i,
  input  cpfp_pkg::cfg_t       cfg_i,
  output cpfp_pkg::upd_t       upd_o,
  output logic [TEMP_BITS-1:0] temp_o
);
  import cpfp_pkg::*;

  localparam int TW = (TEMP_BITS > TIN_W) ? TEMP_BITS : TIN_W;
  localparam int PW = 15 + TEMP_BITS;
  localparam logic [TW-1:0] TMAX = TW'((1 << TEMP_BITS) - 1);

  logic [TW-1:0]     t_wide;
  logic [TW-1:0]     t_clamp;
  logic [14:0]       span_n;
  logic [14:0]       span_s;
  logic [PW-1:0]     comp_n;
  logic [PW-1:0]     comp_s;
  logic              neg_s;
  logic [31:0]       comp_thr_sc;
  logic [31:0]       cold_thr_sc;
  logic [31:0]       nir_sc;
  logic [31:0]       grow_p;
  logic [31:0]       sen_p;
  logic [31:0]       soil_p;
  logic [20:0]       g_ext;
  logic [20:0]       s_ext;
  logic [20:0]       r_ext;
  logic              dark_r7;
  logic              dark_s8;
  logic              shadow_hit;
  logic              bright;
  logic              window_ok;
  logic              snow_hit;
  logic              temp_ok;
  logic              comp_lt;
  logic              cold_lt;
  logic              grow_ok;
  logic              sen_ok;
  logic              soil_ok;

  // Clamp the temperature to the accumulator width
  assign t_wide  = TW'(pix_i.thermal);
  assign t_clamp = (t_wide > TMAX) ? TMAX : t_wide;
  assign temp_o  = TEMP_BITS'(t_clamp);

  // Composite (1 - refl) * T, scaled by 16384; a negative SWIR composite is flagged, NIR clamps at zero
  assign span_n = ({1'b0, pix_i.nir} <= ONE_Q14) ? 15'(ONE_Q14 - {1'b0, pix_i.nir}) : '0;
  assign span_s = ({1'b0, pix_i.swir} <= ONE_Q14) ? 15'(ONE_Q14 - {1'b0, pix_i.swir}) : '0;
  assign comp_n = PW'(span_n) * PW'(temp_o);
  assign comp_s = PW'(span_s) * PW'(temp_o);
  assign neg_s  = ({1'b0, pix_i.swir} > ONE_Q14) && (temp_o != '0);

  assign comp_thr_sc = 32'({cfg_i.comp_thr, 14'd0});
  assign cold_thr_sc = 32'({cfg_i.cold_thr, 14'd0});
  assign comp_lt     = neg_s || (32'(comp_s) < comp_thr_sc);
  assign cold_lt     = neg_s || (32'(comp_s) < cold_thr_sc);

  // Dark tests
  assign dark_r7 = (23'(pix_i.red) * PCT_SCALE) < DARK7_LIM;
  assign dark_s8 = (23'(pix_i.swir) * PCT_SCALE) < DARK8_LIM;

  // Index tests, cross-multiplied with small constants
  assign g_ext = 21'(pix_i.green);
  assign s_ext = 21'(pix_i.swir);
  assign r_ext = 21'(pix_i.red);

  assign shadow_hit = dark_r7 && (32'(comp_n) > SHADOW_COMP) && (pix_i.green != '0) &&
                      (pix_i.nir > pix_i.green) &&
                      ((r_ext * 21'd9) < (s_ext * 21'd11));

  assign window_ok = ((g_ext * 21'd5) > (s_ext * 21'd3)) &&
                     ((g_ext * 21'd3) < (s_ext * 21'd17));
  assign snow_hit  = g_ext > (s_ext * 21'd9);

  assign bright  = pix_i.red > cfg_i.bright_thr;
  assign temp_ok = t_clamp < TW'(cfg_i.temp_thr);

  // Vegetation and soil ratio tests
  assign nir_sc  = {4'd0, pix_i.nir, 12'd0};
  assign grow_p  = 32'(cfg_i.grow_ratio) * 32'(pix_i.red);
  assign sen_p   = 32'(cfg_i.sen_ratio) * 32'(pix_i.green);
  assign soil_p  = 32'(cfg_i.soil_ratio) * 32'(pix_i.swir);
  assign grow_ok = (pix_i.red != '0) && (nir_sc < grow_p);
  assign sen_ok  = (pix_i.green != '0) && (nir_sc < sen_p);
  assign soil_ok = (pix_i.swir != '0) && (nir_sc > soil_p);

  // Walk the tree
  always_comb begin
    upd_o = '0;
    upd_o.cls = CL_NONE;
    if (pix_i.null_px) begin
      upd_o.cls = CL_NONE;
    end else if (cfg_i.shadow_en && shadow_hit) begin
      upd_o.cls = CL_SHADOW;
    end else begin
      upd_o.total = 1'b1;
      if (!bright) begin
        upd_o.cls = dark_r7 ? CL_NONE : CL_AMBIG;
      end else if (!window_ok) begin
        upd_o.cls  = CL_NONE;
        upd_o.snow = snow_hit;
      end else if (!temp_ok) begin
        upd_o.cls = CL_NONE;
      end else if (!comp_lt) begin
        upd_o.cls = dark_s8 ? CL_NONE : CL_AMBIG;
      end else if (!grow_ok) begin
        upd_o.cls = CL_AMBIG;
      end else begin
        upd_o.soil = 1'b1;
        if (!sen_ok || !soil_ok) begin
          upd_o.cls = CL_AMBIG;
        end else begin
          upd_o.cloud = 1'b1;
          if (cold_lt) begin
            upd_o.cls  = CL_COLD;
            upd_o.cold = 1'b1;
          end else begin
            upd_o.cls  = CL_WARM;
            upd_o.warm = 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ rtl/cpfp_accum.sv @@
// Scene accumulators: saturating counters, temperature sums and extremes.
module cpfp_accum #(
  parameter int COUNT_BITS = cpfp_pkg::COUNT_BITS_DEF,
  parameter int TEMP_BITS  = cpfp_pkg::TEMP_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            start_i,
  input  cpfp_pkg::upd_t                  upd_i,
  input  logic [TEMP_BITS-1:0]            temp_i,
  output logic [COUNT_BITS-1:0]           total_o,
  output logic [COUNT_BITS-1:0]           warm_o,
  output logic [COUNT_BITS-1:0]           cold_o,
  output logic [COUNT_BITS-1:0]           snow_o,
  output logic [COUNT_BITS-1:0]           soil_o,
  output logic [COUNT_BITS+TEMP_BITS-1:0] cold_sum_o,
  output logic [COUNT_BITS+TEMP_BITS-1:0] warm_sum_o,
  output logic [TEMP_BITS-1:0]            max_o,
  output logic [TEMP_BITS-1:0]            min_o
);
  import cpfp_pkg::*;

  localparam int SW = COUNT_BITS + TEMP_BITS;

  logic [COUNT_BITS-1:0] total_q, warm_q, cold_q, snow_q, soil_q;
  logic [COUNT_BITS-1:0] total_d, warm_d, cold_d, snow_d, soil_d;
  logic [SW-1:0]         cold_sum_q, warm_sum_q, cold_sum_d, warm_sum_d;
  logic [TEMP_BITS-1:0]  max_q, min_q, max_d, min_d;
  logic [COUNT_BITS-1:0] total_b, warm_b, cold_b, snow_b, soil_b;
  logic [SW-1:0]         cold_sum_b, warm_sum_b;
  logic [TEMP_BITS-1:0]  max_b, min_b;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v,
                                                     input logic inc);
    return (inc && (v != '1)) ? v + COUNT_BITS'(1) : v;
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] v,
                                            input logic [TEMP_BITS-1:0] t,
                                            input logic add);
    logic [SW:0] s;
    s = {1'b0, v} + (SW+1)'(t);
    if (!add) begin
      return v;
    end
    return s[SW] ? '1 : s[SW-1:0];
  endfunction

  // Start of scene: drop the old totals before this pixel is counted
  always_comb begin
    total_b    = start_i ? '0 : total_q;
    warm_b     = start_i ? '0 : warm_q;
    cold_b     = start_i ? '0 : cold_q;
    snow_b     = start_i ? '0 : snow_q;
    soil_b     = start_i ? '0 : soil_q;
    cold_sum_b = start_i ? '0 : cold_sum_q;
    warm_sum_b = start_i ? '0 : warm_sum_q;
    max_b      = start_i ? '0 : max_q;
    min_b      = start_i ? '1 : min_q;
  end

  // Advance each accumulator
  always_comb begin
    total_d    = sat_inc(total_b, upd_i.total);
    warm_d     = sat_inc(warm_b, upd_i.warm);
    cold_d     = sat_inc(cold_b, upd_i.cold);
    snow_d     = sat_inc(snow_b, upd_i.snow);
    soil_d     = sat_inc(soil_b, upd_i.soil);
    cold_sum_d = sat_add(cold_sum_b, temp_i, upd_i.cold);
    warm_sum_d = sat_add(warm_sum_b, temp_i, upd_i.warm);
    max_d      = (upd_i.cloud && (temp_i > max_b)) ? temp_i : max_b;
    min_d      = (upd_i.cloud && (temp_i < min_b)) ? temp_i : min_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      warm_q     <= '0;
      cold_q     <= '0;
      snow_q     <= '0;
      soil_q     <= '0;
      cold_sum_q <= '0;
      warm_sum_q <= '0;
      max_q      <= '0;
      min_q      <= '1;
    end else if (en_i) begin
      total_q    <= total_d;
      warm_q     <= warm_d;
      cold_q     <= cold_d;
      snow_q     <= snow_d;
      soil_q     <= soil_d;
      cold_sum_q <= cold_sum_d;
      warm_sum_q <= warm_sum_d;
      max_q      <= max_d;
      min_q      <= min_d;
    end
  end

  assign total_o    = total_q;
  assign warm_o     = warm_q;
  assign cold_o     = cold_q;
  assign snow_o     = snow_q;
  assign soil_o     = soil_q;
  assign cold_sum_o = cold_sum_q;
  assign warm_sum_o = warm_sum_q;
  assign max_o      = max_q;
  assign min_o      = min_q;

endmodule

@@ rtl/cloud_pixel_first_pass_classifier.sv @@
// Top level of the first-pass cloud pixel classifier with scene statistics.
//
//  channel | handshake                 | word
//  --------+---------------------------+--------------------------------------------
//  in      | in_valid_i / in_ready_o   | start, null flag, four reflectances, temp
//  out     | out_valid_o / out_ready_i | class, five counts, two sums, max, min
//  cfg     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One pixel per clock unless a stalled result holds the pipe; an accepted word reaches the result
// by passing the input register, the class/flag register, then the accumulators and class.
// The accumulator read-modify-write in the last stage sets the one-per-cycle rate.
// Reset loads the register defaults and clears the accumulators (minimum to all ones).
// A stalled result holds the pipe; up to three words sit inside while out_ready_i is low.
module cloud_pixel_first_pass_classifier #(
  parameter int COUNT_BITS = cpfp_pkg::COUNT_BITS_DEF,
  parameter int TEMP_BITS  = cpfp_pkg::TEMP_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [cpfp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cpfp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                start_scene_i,
  input  logic                                pixel_null_i,
  input  logic [cpfp_pkg::REFL_W-1:0]         green_refl_i,
  input  logic [cpfp_pkg::REFL_W-1:0]         red_refl_i,
  input  logic [cpfp_pkg::REFL_W-1:0]         nir_refl_i,
  input  logic [cpfp_pkg::REFL_W-1:0]         swir_refl_i,
  input  logic [cpfp_pkg::TIN_W-1:0]          thermal_temp_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          pixel_class_o,
  output logic [COUNT_BITS-1:0]               total_count_o,
  output logic [COUNT_BITS-1:0]               warm_count_o,
  output logic [COUNT_BITS-1:0]               cold_count_o,
  output logic [COUNT_BITS-1:0]               snow_count_o,
  output logic [COUNT_BITS-1:0]               soil_count_o,
  output logic [COUNT_BITS+TEMP_BITS-1:0]     cold_temp_sum_o,
  output logic [COUNT_BITS+TEMP_BITS-1:0]     warm_temp_sum_o,
  output logic [TEMP_BITS-1:0]                max_cloud_temp_o,
  output logic [TEMP_BITS-1:0]                min_cloud_temp_o
);
  import cpfp_pkg::*;

  cfg_t                 cfg_q;
  logic                 s1_v_q;
  pix_t                 s1_q;
  logic                 s2_v_q;
  upd_t                 s2_upd_q;
  logic [TEMP_BITS-1:0] s2_temp_q;
  logic                 s2_start_q;
  logic                 out_v_q;
  cls_e                 cls_q;
  upd_t                 upd_c;
  logic [TEMP_BITS-1:0] temp_c;
  logic                 adv_out;
  logic                 adv_s2;
  logic                 in_acc;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shadow_en  <= RST_SHADOW_EN;
      cfg_q.bright_thr <= RST_BRIGHT_THR;
      cfg_q.temp_thr   <= RST_TEMP_THR;
      cfg_q.comp_thr   <= RST_COMP_THR;
      cfg_q.cold_thr   <= RST_COLD_THR;
      cfg_q.grow_ratio <= RST_GROW_RATIO;
      cfg_q.sen_ratio  <= RST_SEN_RATIO;
      cfg_q.soil_ratio <= RST_SOIL_RATIO;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SHADOW_EN:  cfg_q.shadow_en  <= cfg_wdata_i[0];
        REG_BRIGHT_THR: cfg_q.bright_thr <= cfg_wdata_i;
        REG_TEMP_THR:   cfg_q.temp_thr   <= cfg_wdata_i[THR_W-1:0];
        REG_COMP_THR:   cfg_q.comp_thr   <= cfg_wdata_i[THR_W-1:0];
        REG_COLD_THR:   cfg_q.cold_thr   <= cfg_wdata_i[THR_W-1:0];
        REG_GROW_RATIO: cfg_q.grow_ratio <= cfg_wdata_i;
        REG_SEN_RATIO:  cfg_q.sen_ratio  <= cfg_wdata_i;
        REG_SOIL_RATIO: cfg_q.soil_ratio <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipe control: each stage moves when the one after it is free or moving
  assign adv_out    = s2_v_q && (!out_v_q || out_ready_i);
  assign adv_s2     = s1_v_q && (!s2_v_q || adv_out);
  assign in_ready_o = !s1_v_q || adv_s2;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (adv_s2) begin
        s1_v_q <= 1'b0;
      end
      if (adv_s2) begin
        s2_v_q <= 1'b1;
      end else if (adv_out) begin
        s2_v_q <= 1'b0;
      end
      if (adv_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.start   <= start_scene_i;
      s1_q.null_px <= pixel_null_i;
      s1_q.green   <= green_refl_i;
      s1_q.red     <= red_refl_i;
      s1_q.nir     <= nir_refl_i;
      s1_q.swir    <= swir_refl_i;
      s1_q.thermal <= thermal_temp_i;
    end
  end

  cpfp_classify #(
    .TEMP_BITS (TEMP_BITS)
  ) u_classify (
    .pix_i  (s1_q),
    .cfg_i  (cfg_q),
    .upd_o  (upd_c),
    .temp_o (temp_c)
  );

  // Class and update flag register
  always_ff @(posedge clk_i) begin
    if (adv_s2) begin
      s2_upd_q   <= upd_c;
      s2_temp_q  <= temp_c;
      s2_start_q <= s1_q.start;
    end
  end

  // Result class register; the accumulators double as the statistics result
  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      cls_q <= s2_upd_q.cls;
    end
  end

  cpfp_accum #(
    .COUNT_BITS (COUNT_BITS),
    .TEMP_BITS  (TEMP_BITS)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv_out),
    .start_i    (s2_start_q),
    .upd_i      (s2_upd_q),
    .temp_i     (s2_temp_q),
    .total_o    (total_count_o),
    .warm_o     (warm_count_o),
    .cold_o     (cold_count_o),
    .snow_o     (snow_count_o),
    .soil_o     (soil_count_o),
    .cold_sum_o (cold_temp_sum_o),
    .warm_sum_o (warm_temp_sum_o),
    .max_o      (max_cloud_temp_o),
    .min_o      (min_cloud_temp_o)
  );

  assign out_valid_o   = out_v_q;
  assign pixel_class_o = cls_q;

endmodule

@@ rtl/cpfp_checker.sv @@
// Port-level checker for the cloud classifier, bound to the top level.
`include "cloud_pixel_first_pass_classifier_assert.svh"

module cpfp_checker #(
  parameter int COUNT_BITS = cpfp_pkg::COUNT_BITS_DEF,
  parameter int TEMP_BITS  = cpfp_pkg::TEMP_BITS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [2:0]                          pixel_class_o,
  input logic [COUNT_BITS-1:0]               total_count_o,
  input logic [COUNT_BITS-1:0]               warm_count_o,
  input logic [COUNT_BITS-1:0]               cold_count_o,
  input logic [COUNT_BITS+TEMP_BITS-1:0]     cold_temp_sum_o,
  input logic [TEMP_BITS-1:0]                max_cloud_temp_o,
  input logic [TEMP_BITS-1:0]                min_cloud_temp_o
);
  import cpfp_pkg::*;

  // A stalled result word holds its class, total count and cold temperature sum
  `CPFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(pixel_class_o) && $stable(total_count_o) &&
    $stable(cold_temp_sum_o), "result word changed while stalled")

  // An ambiguous, warm or cold result pixel has been counted in the total
  `CPFP_ASSERT_NOW(a_total_seen, clk_i, rst_ni,
    out_valid_o && (pixel_class_o == CL_AMBIG || pixel_class_o == CL_WARM ||
    pixel_class_o == CL_COLD), total_count_o != '0, "tree pixel missing from total")

  // A cold cloud shows in the cold count and sets the temperature range
  `CPFP_ASSERT_NOW(a_cold_seen, clk_i, rst_ni, out_valid_o && pixel_class_o == CL_COLD,
    cold_count_o != '0 && max_cloud_temp_o >= min_cloud_temp_o,
    "cold cloud not reflected in statistics")

  // A warm cloud shows in the warm count and sets the temperature range
  `CPFP_ASSERT_NOW(a_warm_seen, clk_i, rst_ni, out_valid_o && pixel_class_o == CL_WARM,
    warm_count_o != '0 && max_cloud_temp_o >= min_cloud_temp_o,
    "warm cloud not reflected in statistics")

endmodule

bind cloud_pixel_first_pass_classifier cpfp_checker #(
  .COUNT_BITS (COUNT_BITS),
  .TEMP_BITS  (TEMP_BITS)
) u_cpfp_checker (.*);
